FILE: sv/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths fixed by the interface
  localparam int unsigned KEY_W = 64;
  localparam int unsigned CTR_W = 64;
  localparam int unsigned AMT_W = 4;
  localparam int unsigned EC_W  = 7;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSHES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FENCES  = 2'd2;

  localparam logic [AMT_W-1:0] WRITES_RST  = 4'd4;
  localparam logic [AMT_W-1:0] FLUSHES_RST = 4'd2;
  localparam logic [AMT_W-1:0] FENCES_RST  = 4'd1;

  // Broadcast from the controller to every cell of the row
  typedef struct packed {
    logic             eval;   // latch compare flags against key
    logic             shift;  // apply insert using latched flags
    logic [KEY_W-1:0] key;
  } skt_bcast_t;

endpackage

FILE: sv/skt_if.sv
`timescale 1ns / 1ps

interface skt_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [skt_pkg::KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface skt_out_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic                     stored;
  logic [skt_pkg::EC_W-1:0]  entry_count;
  logic [skt_pkg::CTR_W-1:0] write_total;
  logic [skt_pkg::CTR_W-1:0] flush_total;
  logic [skt_pkg::CTR_W-1:0] fence_total;

  modport source (output valid, output found, output stored, output entry_count,
                  output write_total, output flush_total, output fence_total,
                  input ready);
  modport sink   (input valid, input found, input stored, input entry_count,
                  input write_total, input flush_total, input fence_total,
                  output ready);
endinterface

FILE: sv/skt_cell.sv
`timescale 1ns / 1ps

module skt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  skt_pkg::skt_bcast_t       bcast,
  input  logic [skt_pkg::KEY_W-1:0] prev_key,
  input  logic                      prev_valid,
  input  logic                      prev_lt,
  output logic [skt_pkg::KEY_W-1:0] key_r,
  output logic                      valid_r,
  output logic                      lt_r,
  output logic                      eq_r
);

  logic [skt_pkg::KEY_W-1:0] key_nxt;
  logic                      valid_nxt;
  logic                      lt_nxt;
  logic                      eq_nxt;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    if (bcast.eval) begin
      lt_nxt = valid_r && (key_r < bcast.key);
      eq_nxt = valid_r && (key_r == bcast.key);
    end
    // Smaller keys hold; the first cell not smaller takes the new key,
    // the rest take their left neighbor.
    if (bcast.shift && !lt_r) begin
      if (prev_lt) begin
        key_nxt   = bcast.key;
        valid_nxt = 1'b1;
      end else begin
        key_nxt   = prev_key;
        valid_nxt = prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
  end

endmodule

FILE: sv/sorted_key_table_insert_search_core.sv
`timescale 1ns / 1ps

// Sorted key table: holds up to CAPACITY 64-bit keys in ascending order in a
// row of cells, one key per cell, with duplicates kept.
// in_ch carries one beat per operation: op (insert or search) and key.
// out_ch returns exactly one beat per operation: found (search), stored
// (insert, low when the table was full), the fill count and the three
// running cost counters after the operation.
// cfg_we/cfg_idx/cfg_wdata write the per-insert amounts added to the write,
// flush and fence counters; write them only while the block is idle.
// Timing: an accepted beat is registered and the sequencer steps from idle
// to evaluate, where its key is broadcast to all cells, which latch their
// compare flags; in the apply step the row shifts (insert) and the result is
// loaded into the output register. A new beat is taken only once the
// compare-then-shift sequence of the cell row has returned to idle.
// The next beat is accepted while a finished result still waits in the
// output register; a stalled receiver holds the block in its final step.
// Reset empties the table, clears the counters and restores the amounts
// 4/2/1; no clearing pass is needed, valid bits in the cells reset at once.
module sorted_key_table_insert_search_core (
  input  logic                            clk,
  input  logic                            rst_n,
  skt_in_if.sink                          in_ch,
  skt_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [skt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [skt_pkg::AMT_W-1:0]       cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Operation in flight
  logic                      op_r, op_nxt;
  logic [skt_pkg::KEY_W-1:0] key_r, key_nxt;

  // Fill count and cost counters
  logic [skt_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [skt_pkg::CTR_W-1:0] wr_cnt_r, wr_cnt_nxt;
  logic [skt_pkg::CTR_W-1:0] fl_cnt_r, fl_cnt_nxt;
  logic [skt_pkg::CTR_W-1:0] fe_cnt_r, fe_cnt_nxt;

  // Configuration
  logic [skt_pkg::AMT_W-1:0] wr_amt_r, wr_amt_nxt;
  logic [skt_pkg::AMT_W-1:0] fl_amt_r, fl_amt_nxt;
  logic [skt_pkg::AMT_W-1:0] fe_amt_r, fe_amt_nxt;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic                      found_r, found_nxt;
  logic                      stored_r, stored_nxt;
  logic [skt_pkg::EC_W-1:0]  ec_r, ec_nxt;
  logic [skt_pkg::CTR_W-1:0] wr_tot_r, wr_tot_nxt;
  logic [skt_pkg::CTR_W-1:0] fl_tot_r, fl_tot_nxt;
  logic [skt_pkg::CTR_W-1:0] fe_tot_r, fe_tot_nxt;

  // Cell row
  skt_pkg::skt_bcast_t       bcast;
  logic [skt_pkg::KEY_W-1:0] cell_key [skt_pkg::CAPACITY];
  logic [skt_pkg::CAPACITY-1:0] cell_valid;
  logic [skt_pkg::CAPACITY-1:0] cell_lt;
  logic [skt_pkg::CAPACITY-1:0] cell_eq;

  logic in_acc;
  logic adv;
  logic ins_ok;
  logic found_w;
  logic [skt_pkg::CNT_W+skt_pkg::EC_W-1:0] fill_ext;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign adv     = !out_valid_r || out_ch.ready;
  assign ins_ok  = (op_r == skt_pkg::OP_INSERT) &&
                   (fill_r < skt_pkg::CNT_W'(skt_pkg::CAPACITY));
  assign found_w = |cell_eq;

  assign bcast.eval  = (state_r == ST_EVAL);
  assign bcast.shift = (state_r == ST_APPLY) && adv && ins_ok;
  assign bcast.key   = key_r;

  genvar gi;
  generate
    for (gi = 0; gi < skt_pkg::CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        // Head cell sees an always-smaller left boundary
        skt_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .bcast      (bcast),
          .prev_key   ('0),
          .prev_valid (1'b0),
          .prev_lt    (1'b1),
          .key_r      (cell_key[gi]),
          .valid_r    (cell_valid[gi]),
          .lt_r       (cell_lt[gi]),
          .eq_r       (cell_eq[gi])
        );
      end else begin : g_body
        skt_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .bcast      (bcast),
          .prev_key   (cell_key[gi-1]),
          .prev_valid (cell_valid[gi-1]),
          .prev_lt    (cell_lt[gi-1]),
          .key_r      (cell_key[gi]),
          .valid_r    (cell_valid[gi]),
          .lt_r       (cell_lt[gi]),
          .eq_r       (cell_eq[gi])
        );
      end
    end
  endgenerate

  // Sequencer, counters and output register
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    fill_nxt      = fill_r;
    wr_cnt_nxt    = wr_cnt_r;
    fl_cnt_nxt    = fl_cnt_r;
    fe_cnt_nxt    = fe_cnt_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    stored_nxt    = stored_r;
    ec_nxt        = ec_r;
    wr_tot_nxt    = wr_tot_r;
    fl_tot_nxt    = fl_tot_r;
    fe_tot_nxt    = fe_tot_r;

    // Drop the held beat once the receiver takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_ch.op;
          key_nxt   = in_ch.key;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        // Hold here until the output register is free
        if (adv) begin
          if (ins_ok) begin
            fill_nxt   = fill_r + skt_pkg::CNT_W'(1);
            wr_cnt_nxt = wr_cnt_r + skt_pkg::CTR_W'(wr_amt_r);
            fl_cnt_nxt = fl_cnt_r + skt_pkg::CTR_W'(fl_amt_r);
            fe_cnt_nxt = fe_cnt_r + skt_pkg::CTR_W'(fe_amt_r);
          end
          out_valid_nxt = 1'b1;
          found_nxt     = (op_r == skt_pkg::OP_SEARCH) && found_w;
          stored_nxt    = ins_ok;
          wr_tot_nxt    = wr_cnt_nxt;
          fl_tot_nxt    = fl_cnt_nxt;
          fe_tot_nxt    = fe_cnt_nxt;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Entry count field keeps the low bits of the fill count
    fill_ext = {{skt_pkg::EC_W{1'b0}}, fill_nxt};
    if (state_r == ST_APPLY && adv) begin
      ec_nxt = fill_ext[skt_pkg::EC_W-1:0];
    end
  end

  // Configuration writes
  always_comb begin
    wr_amt_nxt = wr_amt_r;
    fl_amt_nxt = fl_amt_r;
    fe_amt_nxt = fe_amt_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        skt_pkg::REG_WRITES:  wr_amt_nxt = cfg_wdata;
        skt_pkg::REG_FLUSHES: fl_amt_nxt = cfg_wdata;
        skt_pkg::REG_FENCES:  fe_amt_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    found_r  <= found_nxt;
    stored_r <= stored_nxt;
    ec_r     <= ec_nxt;
    wr_tot_r <= wr_tot_nxt;
    fl_tot_r <= fl_tot_nxt;
    fe_tot_r <= fe_tot_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      wr_cnt_r    <= '0;
      fl_cnt_r    <= '0;
      fe_cnt_r    <= '0;
      wr_amt_r    <= skt_pkg::WRITES_RST;
      fl_amt_r    <= skt_pkg::FLUSHES_RST;
      fe_amt_r    <= skt_pkg::FENCES_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      fl_cnt_r    <= fl_cnt_nxt;
      fe_cnt_r    <= fe_cnt_nxt;
      wr_amt_r    <= wr_amt_nxt;
      fl_amt_r    <= fl_amt_nxt;
      fe_amt_r    <= fe_amt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Port drive: accept only between operations
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.stored      = stored_r;
  assign out_ch.entry_count = ec_r;
  assign out_ch.write_total = wr_tot_r;
  assign out_ch.flush_total = fl_tot_r;
  assign out_ch.fence_total = fe_tot_r;

  // Cell valid bits always track the fill count
  a_valid_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == 32'(fill_r))
    else $error("cell valid bits disagree with fill count");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= skt_pkg::CNT_W'(skt_pkg::CAPACITY))
    else $error("fill count beyond capacity");

  a_fill_only_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_APPLY) |=> $stable(fill_r))
    else $error("fill count moved outside the apply step");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_EVAL))
    else $error("accepted beat did not start a compare");

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(found_r && stored_r))
    else $error("result flags both set");

endmodule
